[rtl/core/vmvf_pkg.sv]
// Shared types, codes and helpers for the variable-file ALU.
// Used by vmvf_exec and vm_variable_file_alu; depends on nothing else.
package vmvf_pkg;

   localparam int VARIABLE_COUNT_DEF = 256;
   localparam int VARIABLE_WIDTH_DEF = 16;
   localparam int OUT_WIDTH          = 16;
   localparam int BLIT_VAR           = 'hF7;

   typedef logic [OUT_WIDTH-1:0] out_word_type;

   typedef enum logic [3:0] {
      MODE_MOV   = 4'd0,
      MODE_ADD   = 4'd1,
      MODE_SUB   = 4'd2,
      MODE_AND   = 4'd3,
      MODE_OR    = 4'd4,
      MODE_SHL   = 4'd5,
      MODE_SHR   = 4'd6,
      MODE_DBNZ  = 4'd7,
      MODE_CMP   = 4'd8,
      MODE_BLIT  = 4'd9
   } mode_type;

   typedef enum logic [1:0] {
      CSRC_VAR   = 2'd0,
      CSRC_IMM16 = 2'd1,
      CSRC_IMM8  = 2'd2
   } csrc_type;

   typedef enum logic [2:0] {
      COND_EQ = 3'd0,
      COND_NE = 3'd1,
      COND_GT = 3'd2,
      COND_GE = 3'd3,
      COND_LT = 3'd4,
      COND_LE = 3'd5
   } cond_type;

   typedef struct packed {
      logic wr_en;
      logic wr_blit;
      logic taken;
   } exec_ctrl_type;

   // Reduce an 8-bit index modulo count (count >= 16) by restoring subtraction.
   function automatic logic [7:0] wrap_index(input logic [7:0] idx, input int unsigned count);
      logic [12:0] v;
      logic [12:0] step;
      v = {5'b0, idx};
      for (int k = 4; k >= 0; k--) begin
         step = 13'(count << k);
         if (v >= step) begin
            v = v - step;
         end
      end
      return v[7:0];
   endfunction

endpackage

[rtl/core/vm_variable_file_alu.sv]
// Top level of the variable-file ALU: variable store, operand forwarding, result register.
// Depends on vmvf_pkg and vmvf_exec.
//
// Usage:
//   Request channel: drive req_* and raise start; a request is taken at every
//   rising edge where start is high and busy is low. busy stays low, so one
//   request can be issued in every cycle.
//   Result channel: rsp_strobe is high for exactly one cycle per request, with
//   rsp_branch_taken and rsp_written_value valid in that cycle. The receiver
//   has no way to stall; it must take the result in that cycle.
//   A taken request passes through the execute-stage registers and then the
//   result register. Throughput: one request per cycle, set by the single
//   read-modify-write of the variable store (two read ports, one write port).
//   Back-to-back requests on the same variable see each other through a
//   forwarding register that covers the write landing at the same edge as
//   the next read.
//   Reset: synchronous, active high. It drops any request in flight and
//   clears every variable to zero at once through per-entry valid bits; an
//   entry whose valid bit is clear reads as zero. No clearing pass is needed.
module vm_variable_file_alu #(
   parameter int VARIABLE_COUNT = vmvf_pkg::VARIABLE_COUNT_DEF,
   parameter int VARIABLE_WIDTH = vmvf_pkg::VARIABLE_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_mode,
   input  logic [7:0]  req_dest_index,
   input  logic [7:0]  req_source_index,
   input  logic [15:0] req_immediate_value,
   input  logic [1:0]  req_compare_source,
   input  logic [2:0]  req_condition_code,
   output logic        rsp_strobe,
   output logic        rsp_branch_taken,
   output logic signed [15:0] rsp_written_value
);

   localparam int IW = $clog2(VARIABLE_COUNT);
   localparam logic [IW-1:0] BLIT_INDEX = IW'(vmvf_pkg::BLIT_VAR % VARIABLE_COUNT);

   logic                      accept;
   logic [IW-1:0]             req_d_idx;
   logic [IW-1:0]             req_s_idx;

   // variable store and its reset-clear valid bits
   logic [VARIABLE_WIDTH-1:0] var_mem [VARIABLE_COUNT];
   logic [VARIABLE_COUNT-1:0] vld_ff;

   // execute stage
   logic                      s1_vld_ff;
   logic [3:0]                mode_ff;
   logic [IW-1:0]             d_idx_ff;
   logic [IW-1:0]             s_idx_ff;
   logic [15:0]               imm_ff;
   logic [1:0]                csrc_ff;
   logic [2:0]                cond_ff;
   logic [VARIABLE_WIDTH-1:0] rd_d_ff;
   logic [VARIABLE_WIDTH-1:0] rd_s_ff;
   logic                      rd_vd_ff;
   logic                      rd_vs_ff;

   // last write, for forwarding
   logic                      wr_vld_ff;
   logic [IW-1:0]             wr_idx_ff;
   logic [VARIABLE_WIDTH-1:0] wr_data_ff;

   logic [VARIABLE_WIDTH-1:0] op_d;
   logic [VARIABLE_WIDTH-1:0] op_s;
   logic [VARIABLE_WIDTH-1:0] exec_value;
   vmvf_pkg::exec_ctrl_type   exec_ctrl;
   logic                      wr_en_in;
   logic [IW-1:0]             wr_idx_in;

   // result register
   logic                      rsp_strobe_ff;
   logic                      rsp_taken_ff;
   vmvf_pkg::out_word_type    rsp_value_ff;

   // The store never blocks a request.
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign req_d_idx = IW'(vmvf_pkg::wrap_index(req_dest_index, VARIABLE_COUNT));
   assign req_s_idx = IW'(vmvf_pkg::wrap_index(req_source_index, VARIABLE_COUNT));

   // Read both operands at accept time; read data lands in the execute stage.
   always_ff @(posedge clock) begin
      if (wr_en_in) begin
         var_mem[wr_idx_in] <= exec_value;
      end
      rd_d_ff  <= var_mem[req_d_idx];
      rd_s_ff  <= var_mem[req_s_idx];
      rd_vd_ff <= vld_ff[req_d_idx];
      rd_vs_ff <= vld_ff[req_s_idx];
      mode_ff  <= req_mode;
      d_idx_ff <= req_d_idx;
      s_idx_ff <= req_s_idx;
      imm_ff   <= req_immediate_value;
      csrc_ff  <= req_compare_source;
      cond_ff  <= req_condition_code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         s1_vld_ff <= 1'b0;
         wr_vld_ff <= 1'b0;
      end else begin
         if (wr_en_in) begin
            vld_ff[wr_idx_in] <= 1'b1;
         end
         s1_vld_ff <= accept;
         wr_vld_ff <= wr_en_in;
      end
   end

   // Hold the write that landed at the same edge as this stage's read.
   always_ff @(posedge clock) begin
      wr_idx_ff  <= wr_idx_in;
      wr_data_ff <= exec_value;
   end

   // Forward the previous write, else take the store; an unwritten entry reads zero.
   always_comb begin
      if (wr_vld_ff && (wr_idx_ff == d_idx_ff)) begin
         op_d = wr_data_ff;
      end else begin
         op_d = rd_vd_ff ? rd_d_ff : '0;
      end
      if (wr_vld_ff && (wr_idx_ff == s_idx_ff)) begin
         op_s = wr_data_ff;
      end else begin
         op_s = rd_vs_ff ? rd_s_ff : '0;
      end
   end

   vmvf_exec #(
      .VARIABLE_WIDTH(VARIABLE_WIDTH)
   ) u_exec (
      .vmode (mode_ff),
      .op_d  (op_d),
      .op_s  (op_s),
      .imm   (imm_ff),
      .csrc  (csrc_ff),
      .cond  (cond_ff),
      .value (exec_value),
      .ctrl  (exec_ctrl)
   );

   // Write back in the same cycle; the blit always targets its fixed variable.
   assign wr_en_in  = s1_vld_ff & exec_ctrl.wr_en;
   assign wr_idx_in = exec_ctrl.wr_blit ? BLIT_INDEX : d_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s1_vld_ff;
      end
   end

   // Narrow or zero-extend the new value to the result width.
   always_ff @(posedge clock) begin
      rsp_taken_ff <= exec_ctrl.taken;
      rsp_value_ff <= vmvf_pkg::out_word_type'(exec_value);
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_branch_taken  = rsp_taken_ff;
   assign rsp_written_value = $signed(rsp_value_ff);

`ifndef SYNTHESIS
   a_result_follows_request: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_strobe)
      else $error("request produced no result two cycles later");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(s1_vld_ff))
      else $error("result without an execute-stage request");

   a_taken_only_on_branch: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_branch_taken) |->
         ($past(mode_ff) == vmvf_pkg::MODE_DBNZ || $past(mode_ff) == vmvf_pkg::MODE_CMP))
      else $error("branch taken on a non-branch operation");

   a_blit_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && mode_ff == vmvf_pkg::MODE_BLIT) |=> (rsp_written_value == '0))
      else $error("blit result not zero");

   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en_in |=> vld_ff[$past(wr_idx_in)])
      else $error("written variable not marked valid");
`endif

endmodule

[rtl/core/vmvf_exec.sv]
// Combinational execute unit: one operation on two operand values.
// Depends on vmvf_pkg for mode, source and condition codes.
module vmvf_exec #(
   parameter int VARIABLE_WIDTH = vmvf_pkg::VARIABLE_WIDTH_DEF
) (
   input  logic [3:0]                vmode,
   input  logic [VARIABLE_WIDTH-1:0] op_d,
   input  logic [VARIABLE_WIDTH-1:0] op_s,
   input  logic [15:0]               imm,
   input  logic [1:0]                csrc,
   input  logic [2:0]                cond,
   output logic [VARIABLE_WIDTH-1:0] value,
   output vmvf_pkg::exec_ctrl_type   ctrl
);

   localparam int SHW = $clog2(VARIABLE_WIDTH);
   localparam int CW  = (VARIABLE_WIDTH > 16) ? VARIABLE_WIDTH : 16;

   logic                      shift_big;
   logic [VARIABLE_WIDTH-1:0] dec_v;
   logic signed [CW-1:0]      cmp_b;
   logic signed [CW-1:0]      cmp_a;
   logic                      hit;

   assign shift_big = (imm >= 16'(VARIABLE_WIDTH));
   assign dec_v     = op_d - VARIABLE_WIDTH'(1);
   assign cmp_b     = CW'($signed(op_d));

   always_comb begin
      case (csrc)
         vmvf_pkg::CSRC_VAR:   cmp_a = CW'($signed(op_s));
         vmvf_pkg::CSRC_IMM16: cmp_a = CW'($signed(imm));
         default:              cmp_a = CW'({8'b0, imm[7:0]});
      endcase
   end

   always_comb begin
      case (cond)
         vmvf_pkg::COND_EQ: hit = (cmp_b == cmp_a);
         vmvf_pkg::COND_NE: hit = (cmp_b != cmp_a);
         vmvf_pkg::COND_GT: hit = (cmp_b >  cmp_a);
         vmvf_pkg::COND_GE: hit = (cmp_b >= cmp_a);
         vmvf_pkg::COND_LT: hit = (cmp_b <  cmp_a);
         vmvf_pkg::COND_LE: hit = (cmp_b <= cmp_a);
         default:           hit = 1'b0;
      endcase
   end

   always_comb begin
      value = '0;
      ctrl  = '0;
      case (vmode)
         vmvf_pkg::MODE_MOV: begin
            value      = op_s;
            ctrl.wr_en = 1'b1;
         end
         vmvf_pkg::MODE_ADD: begin
            value      = op_d + op_s;
            ctrl.wr_en = 1'b1;
         end
         vmvf_pkg::MODE_SUB: begin
            value      = op_d - op_s;
            ctrl.wr_en = 1'b1;
         end
         vmvf_pkg::MODE_AND: begin
            value      = op_d & VARIABLE_WIDTH'(imm);
            ctrl.wr_en = 1'b1;
         end
         vmvf_pkg::MODE_OR: begin
            value      = op_d | VARIABLE_WIDTH'(imm);
            ctrl.wr_en = 1'b1;
         end
         vmvf_pkg::MODE_SHL: begin
            value      = shift_big ? '0 : (op_d << imm[SHW-1:0]);
            ctrl.wr_en = 1'b1;
         end
         vmvf_pkg::MODE_SHR: begin
            value      = shift_big ? '0 : (op_d >> imm[SHW-1:0]);
            ctrl.wr_en = 1'b1;
         end
         vmvf_pkg::MODE_DBNZ: begin
            value      = dec_v;
            ctrl.wr_en = 1'b1;
            ctrl.taken = (dec_v != '0);
         end
         vmvf_pkg::MODE_CMP: begin
            value      = op_d;
            ctrl.taken = hit;
         end
         vmvf_pkg::MODE_BLIT: begin
            value        = '0;
            ctrl.wr_en   = 1'b1;
            ctrl.wr_blit = 1'b1;
         end
         default: begin
            value = '0;
            ctrl  = '0;
         end
      endcase
   end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for vm_variable_file_alu: a directed walk, then random requests.
// Depends on vmvf_pkg and the RTL of vm_variable_file_alu; reads no files.
module tb_top;

   // Codes the package leaves unnamed. The block must handle them anyway.
   localparam logic [3:0] MODE_UNDEF_LO = 4'd10;
   localparam logic [3:0] MODE_UNDEF_HI = 4'd15;
   localparam logic [1:0] CSRC_IMM8_ALT = 2'd3;
   localparam logic [2:0] COND_NEVER_6  = 3'd6;
   localparam logic [2:0] COND_NEVER_7  = 3'd7;

   localparam int unsigned RANDOM_REQUESTS = 1325;
   localparam int unsigned MAX_GAP         = 18;
   localparam int unsigned IDLE_LIMIT      = 400;
   localparam int unsigned DRAIN_CYCLES    = 8;
   localparam int unsigned RESET_CYCLES    = 12;

   typedef struct packed {
      logic        taken;
      logic [15:0] value;
   } alu_outcome_type;

   // Shadow of the variable store plus the queue of outcomes still owed by the block.
   class var_file_tracker_type;
      logic [15:0]     vars [256];
      alu_outcome_type owed_outcomes [$];
      int unsigned     error_count;

      function new();
         foreach (vars[i]) vars[i] = '0;
         error_count = 0;
      endfunction

      // Apply one accepted request to the shadow store and queue its outcome.
      function void note_request(input logic [3:0] mode, input logic [7:0] dst,
                                 input logic [7:0] src, input logic [15:0] imm,
                                 input logic [1:0] csrc, input logic [2:0] cond);
         logic [15:0]        cur;
         logic [15:0]        nv;
         logic               taken;
         logic signed [16:0] lhs;
         logic signed [16:0] rhs;
         alu_outcome_type    outcome;
         cur   = vars[dst];
         nv    = '0;
         taken = 1'b0;
         case (mode)
            vmvf_pkg::MODE_MOV: begin
               nv = vars[src];
               vars[dst] = nv;
            end
            vmvf_pkg::MODE_ADD: begin
               nv = cur + vars[src];
               vars[dst] = nv;
            end
            vmvf_pkg::MODE_SUB: begin
               nv = cur - vars[src];
               vars[dst] = nv;
            end
            vmvf_pkg::MODE_AND: begin
               nv = cur & imm;
               vars[dst] = nv;
            end
            vmvf_pkg::MODE_OR: begin
               nv = cur | imm;
               vars[dst] = nv;
            end
            vmvf_pkg::MODE_SHL: begin
               nv = (imm >= 16'd16) ? 16'd0 : (cur << imm[3:0]);
               vars[dst] = nv;
            end
            vmvf_pkg::MODE_SHR: begin
               nv = (imm >= 16'd16) ? 16'd0 : (cur >> imm[3:0]);
               vars[dst] = nv;
            end
            vmvf_pkg::MODE_DBNZ: begin
               nv = cur - 16'd1;
               vars[dst] = nv;
               taken = (nv != 16'd0);
            end
            vmvf_pkg::MODE_CMP: begin
               lhs = {cur[15], cur};
               if (csrc == vmvf_pkg::CSRC_VAR) begin
                  rhs = {vars[src][15], vars[src]};
               end else if (csrc == vmvf_pkg::CSRC_IMM16) begin
                  rhs = {imm[15], imm};
               end else begin
                  rhs = {9'b0, imm[7:0]};
               end
               case (cond)
                  vmvf_pkg::COND_EQ: taken = (lhs == rhs);
                  vmvf_pkg::COND_NE: taken = (lhs != rhs);
                  vmvf_pkg::COND_GT: taken = (lhs > rhs);
                  vmvf_pkg::COND_GE: taken = (lhs >= rhs);
                  vmvf_pkg::COND_LT: taken = (lhs < rhs);
                  vmvf_pkg::COND_LE: taken = (lhs <= rhs);
                  default: taken = 1'b0;
               endcase
               nv = cur;
            end
            vmvf_pkg::MODE_BLIT: begin
               vars[8'(vmvf_pkg::BLIT_VAR)] = '0;
               nv = '0;
            end
            default: ;
         endcase
         outcome.taken = taken;
         outcome.value = nv;
         owed_outcomes.push_back(outcome);
      endfunction

      // Compare one result against the oldest owed outcome.
      function void check_result(input logic taken, input logic [15:0] value);
         alu_outcome_type want;
         if (owed_outcomes.size() == 0) begin
            $error("result with no request outstanding: taken %0b, value %0d",
                   taken, $signed(value));
            error_count++;
            return;
         end
         want = owed_outcomes.pop_front();
         if (taken !== want.taken) begin
            $error("rsp_branch_taken: expected %0b, got %0b", want.taken, taken);
            error_count++;
         end
         if (value !== want.value) begin
            $error("rsp_written_value: expected %0d, got %0d",
                   $signed(want.value), $signed(value));
            error_count++;
         end
      endfunction

      function int unsigned outstanding();
         return owed_outcomes.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [3:0]         req_mode = '0;
   logic [7:0]         req_dest_index = '0;
   logic [7:0]         req_source_index = '0;
   logic [15:0]        req_immediate_value = '0;
   logic [1:0]         req_compare_source = '0;
   logic [2:0]         req_condition_code = '0;
   logic               rsp_strobe;
   logic               rsp_branch_taken;
   logic signed [15:0] rsp_written_value;

   var_file_tracker_type tracker = new();
   int unsigned          calm_left = 0;
   int unsigned          idle_cycles = 0;

   vm_variable_file_alu i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_dest_index     (req_dest_index),
      .req_source_index   (req_source_index),
      .req_immediate_value(req_immediate_value),
      .req_compare_source (req_compare_source),
      .req_condition_code (req_condition_code),
      .rsp_strobe         (rsp_strobe),
      .rsp_branch_taken   (rsp_branch_taken),
      .rsp_written_value  (rsp_written_value)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Sample both channels at the edge. Inputs change only through nonblocking
   // writes at this same edge, so the values read here are the pre-edge ones.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && busy === 1'b0) begin
            tracker.note_request(req_mode, req_dest_index, req_source_index,
                                 req_immediate_value, req_compare_source,
                                 req_condition_code);
         end
         if (rsp_strobe) begin
            tracker.check_result(rsp_branch_taken, rsp_written_value);
         end
      end
   end

   // Count cycles in which neither a request nor a result moves; give up when
   // the count runs past anything a correct block could need.
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Draw the wait before the next request. Now and then run a burst of
   // back-to-back requests so the forwarding path gets hammered.
   function automatic int unsigned draw_gap();
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 99) < 6) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, MAX_GAP);
   endfunction

   // Favor a handful of variables so requests chain on each other's results;
   // keep the blit's variable and the full index range in the mix.
   function automatic logic [7:0] pick_index();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 8'($urandom_range(0, 7));
      if (roll < 78) return 8'(vmvf_pkg::BLIT_VAR);
      return 8'($urandom_range(0, 255));
   endfunction

   // Present one request after the drawn gap and hold it until it is taken.
   task automatic issue(input logic [3:0] mode, input logic [7:0] dst,
                        input logic [7:0] src, input logic [15:0] imm,
                        input logic [1:0] csrc, input logic [2:0] cond);
      int unsigned gap;
      gap = draw_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start               <= 1'b1;
      req_mode            <= mode;
      req_dest_index      <= dst;
      req_source_index    <= src;
      req_immediate_value <= imm;
      req_compare_source  <= csrc;
      req_condition_code  <= cond;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic issue_random();
      logic [3:0]  mode;
      logic [7:0]  dst;
      logic [7:0]  src;
      logic [15:0] imm;
      logic [1:0]  csrc;
      logic [2:0]  cond;
      if ($urandom_range(0, 99) < 4) begin
         mode = 4'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI));
      end else begin
         mode = 4'($urandom_range(vmvf_pkg::MODE_MOV, vmvf_pkg::MODE_BLIT));
      end
      dst  = pick_index();
      src  = pick_index();
      csrc = 2'($urandom_range(0, 3));
      cond = 3'($urandom_range(0, 7));
      imm  = 16'($urandom);
      // Keep most shift amounts near the width so both sides of the cutoff show up.
      if ((mode == vmvf_pkg::MODE_SHL || mode == vmvf_pkg::MODE_SHR) &&
          $urandom_range(0, 99) < 75) begin
         imm = 16'($urandom_range(0, 17));
      end
      // Compare against corner immediates and small values, which the
      // small-index variables tend to hold.
      if (mode == vmvf_pkg::MODE_CMP && $urandom_range(0, 99) < 50) begin
         case ($urandom_range(0, 5))
            0: imm = 16'h0000;
            1: imm = 16'h0001;
            2: imm = 16'hFFFF;
            3: imm = 16'h8000;
            4: imm = 16'h7FFF;
            default: imm = 16'($urandom_range(0, 3));
         endcase
      end
      issue(mode, dst, src, imm, csrc, cond);
   endtask

   initial begin
      // Hold reset, then release it at an edge.
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Build the extremes: most negative, most positive, and a wrapping add.
      issue(vmvf_pkg::MODE_OR, 8'd0, 8'd0, 16'h8000, vmvf_pkg::CSRC_VAR, vmvf_pkg::COND_EQ);
      issue(vmvf_pkg::MODE_OR, 8'd1, 8'd0, 16'h7FFF, vmvf_pkg::CSRC_VAR, vmvf_pkg::COND_EQ);
      issue(vmvf_pkg::MODE_MOV, 8'd255, 8'd1, 16'h0000, vmvf_pkg::CSRC_VAR,
            vmvf_pkg::COND_EQ);
      issue(vmvf_pkg::MODE_ADD, 8'd1, 8'd255, 16'h0000, vmvf_pkg::CSRC_VAR,
            vmvf_pkg::COND_EQ);
      issue(vmvf_pkg::MODE_SUB, 8'd0, 8'd1, 16'h0000, vmvf_pkg::CSRC_VAR, vmvf_pkg::COND_EQ);
      // Compare against a variable, both immediate widths and the spare source code.
      issue(vmvf_pkg::MODE_CMP, 8'd0, 8'd1, 16'h0000, vmvf_pkg::CSRC_VAR, vmvf_pkg::COND_GT);
      issue(vmvf_pkg::MODE_CMP, 8'd0, 8'd1, 16'h8000, vmvf_pkg::CSRC_IMM16,
            vmvf_pkg::COND_GE);
      issue(vmvf_pkg::MODE_CMP, 8'd1, 8'd0, 16'hFFFE, vmvf_pkg::CSRC_IMM8,
            vmvf_pkg::COND_LT);
      issue(vmvf_pkg::MODE_CMP, 8'd255, 8'd0, 16'h00FE, CSRC_IMM8_ALT, vmvf_pkg::COND_LE);
      issue(vmvf_pkg::MODE_CMP, 8'd255, 8'd255, 16'h0000, vmvf_pkg::CSRC_VAR,
            vmvf_pkg::COND_EQ);
      issue(vmvf_pkg::MODE_CMP, 8'd255, 8'd255, 16'hFFFF, vmvf_pkg::CSRC_VAR,
            vmvf_pkg::COND_NE);
      // Conditions that are never taken, even where eq would hold.
      issue(vmvf_pkg::MODE_CMP, 8'd255, 8'd255, 16'h0000, vmvf_pkg::CSRC_VAR, COND_NEVER_6);
      issue(vmvf_pkg::MODE_CMP, 8'd255, 8'd255, 16'hFFFF, vmvf_pkg::CSRC_VAR, COND_NEVER_7);
      // Mask and shifts, including amounts at and past the width.
      issue(vmvf_pkg::MODE_AND, 8'd1, 8'd0, 16'h00FF, vmvf_pkg::CSRC_VAR, vmvf_pkg::COND_EQ);
      issue(vmvf_pkg::MODE_SHL, 8'd255, 8'd0, 16'd15, vmvf_pkg::CSRC_VAR, vmvf_pkg::COND_EQ);
      issue(vmvf_pkg::MODE_SHL, 8'd1, 8'd0, 16'd16, vmvf_pkg::CSRC_VAR, vmvf_pkg::COND_EQ);
      issue(vmvf_pkg::MODE_SHR, 8'd0, 8'd0, 16'd1, vmvf_pkg::CSRC_VAR, vmvf_pkg::COND_EQ);
      issue(vmvf_pkg::MODE_SHR, 8'd0, 8'd0, 16'hFFFF, vmvf_pkg::CSRC_VAR, vmvf_pkg::COND_EQ);
      // Decrement from zero wraps and branches; decrement to zero falls through.
      issue(vmvf_pkg::MODE_DBNZ, 8'd2, 8'd0, 16'h0000, vmvf_pkg::CSRC_VAR,
            vmvf_pkg::COND_EQ);
      issue(vmvf_pkg::MODE_OR, 8'd3, 8'd0, 16'h0001, vmvf_pkg::CSRC_VAR, vmvf_pkg::COND_EQ);
      issue(vmvf_pkg::MODE_DBNZ, 8'd3, 8'd0, 16'h0000, vmvf_pkg::CSRC_VAR,
            vmvf_pkg::COND_EQ);
      // Blit clears its fixed variable; read it back through a move.
      issue(vmvf_pkg::MODE_OR, 8'(vmvf_pkg::BLIT_VAR), 8'd0, 16'h1234, vmvf_pkg::CSRC_VAR,
            vmvf_pkg::COND_EQ);
      issue(vmvf_pkg::MODE_BLIT, 8'd5, 8'd6, 16'hFFFF, vmvf_pkg::CSRC_IMM16,
            vmvf_pkg::COND_NE);
      issue(vmvf_pkg::MODE_MOV, 8'd4, 8'(vmvf_pkg::BLIT_VAR), 16'h0000, vmvf_pkg::CSRC_VAR,
            vmvf_pkg::COND_EQ);
      // Undefined modes must leave the store alone.
      issue(MODE_UNDEF_LO, 8'd2, 8'd3, 16'hFFFF, vmvf_pkg::CSRC_IMM16, vmvf_pkg::COND_EQ);
      issue(MODE_UNDEF_HI, 8'd2, 8'd3, 16'hFFFF, CSRC_IMM8_ALT, COND_NEVER_7);
      issue(vmvf_pkg::MODE_MOV, 8'd5, 8'd2, 16'h0000, vmvf_pkg::CSRC_VAR, vmvf_pkg::COND_EQ);

      repeat (RANDOM_REQUESTS) issue_random();
      start <= 1'b0;

      // Drain the owed results, then keep watching for stray strobes.
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
